// ===== design/skrc_pkg.sv =====
package skrc_pkg;

   localparam int MAX_LEN   = 64;
   localparam int ADDR_W    = $clog2(MAX_LEN);
   localparam int CNT_W     = $clog2(MAX_LEN + 1);

   localparam int KERN_W    = 16;
   localparam int LOAD_W    = 32;
   localparam int DEFL_W    = 48;
   localparam int SCALE_W   = 32;

   localparam int PROD_W    = KERN_W + LOAD_W;
   localparam int ACC_W     = PROD_W + ADDR_W;
   localparam int SHIFT     = 47;
   localparam int LO_W      = 27;
   localparam int HI_W      = ACC_W - LO_W;
   localparam int SHIFT_REM = SHIFT - LO_W;
   localparam int MUL_A_W   = ((HI_W > LO_W + 1) ? HI_W : LO_W + 1) + 1;
   localparam int MUL_P_W   = MUL_A_W + SCALE_W + 1;
   localparam int PL_W      = LO_W + SCALE_W;
   localparam int PH_W      = HI_W + SCALE_W;
   localparam int QSUM_W    = PH_W + 1;
   localparam int Q_W       = QSUM_W - SHIFT_REM;
   localparam int DIFF_W    = ((Q_W > DEFL_W) ? Q_W : DEFL_W) + 1;

   typedef struct packed {
      logic signed [KERN_W-1:0] kernel_value;
      logic signed [LOAD_W-1:0] load_value;
      logic signed [DEFL_W-1:0] deflection_in;
      logic                     last;
   } req_item_type;

   typedef struct packed {
      logic signed [DEFL_W-1:0] deflection_out;
      logic                     last_out;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_MAC,
      ST_DRAIN,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_COMBINE,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic              load_wr;
      logic [ADDR_W-1:0] wr_addr;
      logic              mac_issue;
      logic              acc_first;
      logic [ADDR_W-1:0] i_addr;
      logic [ADDR_W-1:0] k_addr;
      logic [ADDR_W-1:0] j_addr;
      logic              mul_lo;
      logic              mul_hi;
      logic              combine;
      logic              result_wr;
      logic              result_last;
   } cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic out_busy;
   } status_type;

endpackage

// ===== design/skrc_ctrl.sv =====
module skrc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_ready,
   input  skrc_pkg::status_type status,
   output skrc_pkg::cmd_type    cmd
);
   import skrc_pkg::*;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] i_ff, i_in;
   logic [ADDR_W-1:0] j_ff, j_in;
   logic              accept;
   logic              row_close;
   logic              i_last;
   logic              j_last;

   assign accept    = req_valid && (state_ff == ST_LOAD);
   assign row_close = req_last || ((count_ff + CNT_W'(1)) == CNT_W'(MAX_LEN));
   assign i_last    = (CNT_W'(i_ff) + CNT_W'(1)) == count_ff;
   assign j_last    = (CNT_W'(j_ff) + CNT_W'(1)) == count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept && row_close) state_in = ST_MAC;
         end
         ST_MAC: begin
            if (i_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) state_in = ST_MUL_LO;
         end
         ST_MUL_LO:  state_in = ST_MUL_HI;
         ST_MUL_HI:  state_in = ST_COMBINE;
         ST_COMBINE: state_in = ST_RESULT;
         ST_RESULT: begin
            if (!status.out_busy) state_in = j_last ? ST_LOAD : ST_MAC;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) count_in = count_ff + CNT_W'(1);
         end
         ST_MAC: begin
            i_in = i_last ? '0 : i_ff + ADDR_W'(1);
         end
         ST_RESULT: begin
            if (!status.out_busy) begin
               if (j_last) begin
                  count_in = '0;
                  j_in     = '0;
               end else begin
                  j_in = j_ff + ADDR_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      req_ready       = (state_ff == ST_LOAD);
      cmd.load_wr     = accept;
      cmd.wr_addr     = count_ff[ADDR_W-1:0];
      cmd.mac_issue   = (state_ff == ST_MAC);
      cmd.acc_first   = (i_ff == '0);
      cmd.i_addr      = i_ff;
      cmd.k_addr      = (j_ff >= i_ff) ? (j_ff - i_ff) : (i_ff - j_ff);
      cmd.j_addr      = j_ff;
      cmd.mul_lo      = (state_ff == ST_MUL_LO);
      cmd.mul_hi      = (state_ff == ST_MUL_HI);
      cmd.combine     = (state_ff == ST_COMBINE);
      cmd.result_wr   = (state_ff == ST_RESULT) && !status.out_busy;
      cmd.result_last = j_last;
   end

endmodule

// ===== design/skrc_dp.sv =====
module skrc_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  skrc_pkg::req_item_type req_data,
   input  logic                   csr_valid,
   input  logic [31:0]            csr_data,
   input  skrc_pkg::cmd_type      cmd,
   output skrc_pkg::status_type   status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output skrc_pkg::rsp_item_type rsp_data
);
   import skrc_pkg::*;

   localparam logic signed [DIFF_W-1:0] SAT_MAX =
      {{(DIFF_W-DEFL_W+1){1'b0}}, {(DEFL_W-1){1'b1}}};
   localparam logic signed [DIFF_W-1:0] SAT_MIN =
      {{(DIFF_W-DEFL_W+1){1'b1}}, {(DEFL_W-1){1'b0}}};

   logic signed [KERN_W-1:0] kern_mem [MAX_LEN];
   logic signed [LOAD_W-1:0] load_mem [MAX_LEN];
   logic signed [DEFL_W-1:0] defl_mem [MAX_LEN];

   logic [SCALE_W-1:0]       scale_ff;
   logic signed [KERN_W-1:0] kern_rd_ff;
   logic signed [LOAD_W-1:0] load_rd_ff;
   logic signed [DEFL_W-1:0] defl_rd_ff;
   logic                     v1_ff, first1_ff;
   logic                     v2_ff, first2_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic [PL_W-1:0]          pl_ff;
   logic signed [PH_W-1:0]   ph_ff;
   logic signed [Q_W-1:0]    q_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_item_type             rsp_data_ff;

   logic signed [MUL_A_W-1:0]   mul_a;
   logic signed [SCALE_W:0]     mul_b;
   logic signed [MUL_P_W-1:0]   mul_p;
   logic signed [QSUM_W-1:0]    qsum;
   logic signed [DIFF_W-1:0]    diff;
   logic signed [DEFL_W-1:0]    result;

   // row stores
   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         kern_mem[cmd.wr_addr] <= req_data.kernel_value;
         load_mem[cmd.wr_addr] <= req_data.load_value;
         defl_mem[cmd.wr_addr] <= req_data.deflection_in;
      end
      if (cmd.mac_issue) begin
         kern_rd_ff <= kern_mem[cmd.k_addr];
         load_rd_ff <= load_mem[cmd.i_addr];
         defl_rd_ff <= defl_mem[cmd.j_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else begin
         if (csr_valid) scale_ff <= csr_data;
         v1_ff <= cmd.mac_issue;
         v2_ff <= v1_ff;
      end
   end

   // multiply-accumulate pipe
   always_ff @(posedge clock) begin
      first1_ff <= cmd.acc_first;
      first2_ff <= first1_ff;
      prod_ff   <= load_rd_ff * kern_rd_ff;
      if (v2_ff) begin
         acc_ff <= (first2_ff ? '0 : acc_ff)
                 + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end
   end

   // scale multiply, split into low and high halves of the sum
   always_comb begin
      if (cmd.mul_hi) begin
         mul_a = {{(MUL_A_W-HI_W){acc_ff[ACC_W-1]}}, acc_ff[ACC_W-1:LO_W]};
      end else begin
         mul_a = {{(MUL_A_W-LO_W){1'b0}}, acc_ff[LO_W-1:0]};
      end
      mul_b = {1'b0, scale_ff};
      mul_p = mul_a * mul_b;
   end

   assign qsum = {{(QSUM_W-PH_W){ph_ff[PH_W-1]}}, ph_ff}
               + {{(QSUM_W-SCALE_W){1'b0}}, pl_ff[PL_W-1:LO_W]};

   always_ff @(posedge clock) begin
      if (cmd.mul_lo) pl_ff <= mul_p[PL_W-1:0];
      if (cmd.mul_hi) ph_ff <= mul_p[PH_W-1:0];
      if (cmd.combine) q_ff <= qsum[QSUM_W-1:SHIFT_REM];
   end

   // subtract and saturate
   always_comb begin
      diff = {{(DIFF_W-DEFL_W){defl_rd_ff[DEFL_W-1]}}, defl_rd_ff}
           - {{(DIFF_W-Q_W){q_ff[Q_W-1]}}, q_ff};
      if (diff > SAT_MAX) begin
         result = SAT_MAX[DEFL_W-1:0];
      end else if (diff < SAT_MIN) begin
         result = SAT_MIN[DEFL_W-1:0];
      end else begin
         result = diff[DEFL_W-1:0];
      end
   end

   // output register
   always_comb begin
      if (cmd.result_wr) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.result_wr) begin
         rsp_data_ff.deflection_out <= result;
         rsp_data_ff.last_out       <= cmd.result_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;
   assign status.pipe_busy = v1_ff || v2_ff;
   assign status.out_busy  = rsp_valid_ff && !rsp_ready;

endmodule

// ===== design/symmetric_kernel_row_convolution_core.sv =====
// channel  | handshake             | beat
// ---------+-----------------------+---------------------------------------------
// req      | req_valid, req_ready  | req_data: kernel, load, deflection, last
// rsp      | rsp_valid, rsp_ready  | rsp_data: deflection_out, last_out
// csr      | csr_valid, csr_ready  | csr_data: scale
//
// a row of n beats loads one beat per accepted req; each of the n results then
// takes a pass over the row on the single multiply-accumulate pipe, a drain, the
// low and high halves on the shared scale multiplier, a combine and a result step
// reset is synchronous: it clears the controller, the counters, scale and rsp_valid
// the result register lets the next result be computed while one waits; a stalled
// rsp holds the controller in its result step, and req is taken only between rows
module symmetric_kernel_row_convolution_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  skrc_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output skrc_pkg::rsp_item_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [31:0]            csr_data
);
   import skrc_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   skrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   skrc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== dv/symmetric_kernel_row_convolution_core_tb.sv =====
`timescale 1ns / 1ps

module symmetric_kernel_row_convolution_core_tb;
   import skrc_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned HOLD_CYCLES = 1000;
   localparam int unsigned PHASE_BEATS = 100;

   class deflection_tracker;
      logic [SCALE_W-1:0]        scale;
      logic signed [KERN_W-1:0]  kernel_row [MAX_LEN];
      logic signed [LOAD_W-1:0]  load_row [MAX_LEN];
      logic signed [DEFL_W-1:0]  deflection_row [MAX_LEN];
      int unsigned               fill;
      rsp_item_type              awaited [$];
      int unsigned               errors;
      int unsigned               beats;
      int unsigned               rows;
      int unsigned               checked;
      int unsigned               clamped;

      function new();
         scale = '0;
         fill = 0;
         errors = 0;
         beats = 0;
         rows = 0;
         checked = 0;
         clamped = 0;
      endfunction

      function void take_request(req_item_type it);
         longint                 acc;
         logic signed [95:0]     wide_sum;
         logic signed [95:0]     wide_scale;
         logic signed [95:0]     wide_defl;
         logic signed [95:0]     quot;
         logic signed [95:0]     upd;
         logic signed [95:0]     top;
         logic signed [95:0]     bottom;
         rsp_item_type           res;
         int unsigned            d;
         if (fill >= MAX_LEN) fill = 0;
         kernel_row[fill] = it.kernel_value;
         load_row[fill] = it.load_value;
         deflection_row[fill] = it.deflection_in;
         fill++;
         beats++;
         if (!it.last && fill < MAX_LEN) return;
         top = 96'sh7FFF_FFFF_FFFF;
         bottom = -top - 1;
         wide_scale = {64'd0, scale};
         for (int unsigned j = 0; j < fill; j++) begin
            acc = 0;
            for (int unsigned i = 0; i < fill; i++) begin
               d = (i > j) ? i - j : j - i;
               acc += longint'(load_row[i]) * longint'(kernel_row[d]);
            end
            wide_sum = 96'(acc);
            wide_defl = 96'(deflection_row[j]);
            quot = (wide_sum * wide_scale) >>> SHIFT;
            upd = wide_defl - quot;
            if (upd > top) begin
               upd = top;
               clamped++;
            end else if (upd < bottom) begin
               upd = bottom;
               clamped++;
            end
            res.deflection_out = upd[DEFL_W-1:0];
            res.last_out = (j + 1 == fill);
            awaited.push_back(res);
         end
         fill = 0;
         rows++;
      endfunction

      function void check_deflection(rsp_item_type got);
         rsp_item_type want;
         if (awaited.size() == 0) begin
            $error("unexpected result: deflection_out %0d, last_out %0b",
                   got.deflection_out, got.last_out);
            errors++;
            return;
         end
         want = awaited.pop_front();
         checked++;
         if (got.deflection_out !== want.deflection_out) begin
            $error("deflection_out: expected %0d, actual %0d",
                   want.deflection_out, got.deflection_out);
            errors++;
         end
         if (got.last_out !== want.last_out) begin
            $error("last_out: expected %0b, actual %0b", want.last_out, got.last_out);
            errors++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_item_type        req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_item_type        rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [31:0]         csr_data = '0;

   deflection_tracker   board = new();
   int unsigned         cycle_count = 0;
   int unsigned         scale_writes = 0;
   bit                  send_calm = 1'b0;

   symmetric_kernel_row_convolution_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("symmetric_kernel_row_convolution_core_tb: done, errors");
         $finish;
      end
   end

   function automatic logic [63:0] pick_field(int unsigned w);
      logic [63:0] mask;
      logic [63:0] v;
      mask = (w >= 64) ? '1 : ((64'd1 << w) - 1);
      case ($urandom_range(0, 9))
         0: v = mask >> 1;
         1: v = ~(mask >> 1);
         2: v = '0;
         3: v = '1;
         4: v = 64'($urandom_range(0, 7));
         5: v = -64'($urandom_range(1, 8));
         default: v = {$urandom, $urandom};
      endcase
      return v & mask;
   endfunction

   function automatic req_item_type make_beat(logic [KERN_W-1:0] k, logic [LOAD_W-1:0] l,
                                              logic [DEFL_W-1:0] d, logic last);
      req_item_type it;
      it.kernel_value = k;
      it.load_value = l;
      it.deflection_in = d;
      it.last = last;
      return it;
   endfunction

   function automatic req_item_type random_beat(logic last);
      logic [63:0] k;
      logic [63:0] l;
      logic [63:0] d;
      k = pick_field(KERN_W);
      l = pick_field(LOAD_W);
      d = pick_field(DEFL_W);
      return make_beat(k[KERN_W-1:0], l[LOAD_W-1:0], d[DEFL_W-1:0], last);
   endfunction

   task automatic send_beat(req_item_type it);
      int unsigned gap;
      gap = send_calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (!req_ready);
      board.take_request(it);
   endtask

   task automatic send_row(int unsigned n, logic full_last);
      send_calm = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < n; i++)
         send_beat(random_beat((i + 1 == n) ? ((n == MAX_LEN) ? full_last : 1'b1) : 1'b0));
   endtask

   task automatic write_scale(logic [31:0] value);
      req_valid <= 1'b0;
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.scale = value;
      scale_writes++;
   endtask

   task automatic drain_rows();
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   // result side: random stalls, calm stretches and one long hold-off
   initial begin
      int unsigned gap;
      bit          calm;
      bit          held;
      calm = 1'b0;
      held = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 19) == 0) calm = ~calm;
         gap = calm ? 0 : $urandom_range(0, 12);
         if (!held && board.checked >= 60) begin
            held = 1'b1;
            gap = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         board.check_deflection(rsp_data);
      end
   end

   initial begin
      logic [31:0]  phase_scale [5];
      int unsigned  phase_start;
      int unsigned  pick;
      int unsigned  n;
      phase_scale[0] = 32'd0;
      phase_scale[1] = 32'd1;
      phase_scale[2] = $urandom;
      phase_scale[3] = 32'h8000_0000;
      phase_scale[4] = 32'hFFFF_FFFF;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      write_scale(32'hFFFF_FFFF);

      // single-beat rows: clamp high, clamp low, kernel and load extremes
      send_beat(make_beat(16'h7FFF, 32'h8000_0000, 48'h7FFF_FFFF_FFFF, 1'b1));
      send_beat(make_beat(16'h7FFF, 32'h7FFF_FFFF, 48'h8000_0000_0000, 1'b1));
      send_beat(make_beat(16'h8000, 32'h8000_0000, 48'h0, 1'b1));
      send_beat(make_beat(16'h8000, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1));
      // short rows with mixed extremes
      send_beat(make_beat(16'h0, 32'h0, 48'h0, 1'b0));
      send_beat(make_beat(16'hFFFF, 32'hFFFF_FFFF, 48'h1, 1'b1));
      send_beat(make_beat(16'h8000, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF, 1'b0));
      send_beat(make_beat(16'h7FFF, 32'h8000_0000, 48'h8000_0000_0000, 1'b0));
      send_beat(make_beat(16'h0001, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF, 1'b1));
      for (int unsigned i = 0; i < 4; i++)
         send_beat(make_beat(i[0] ? 16'h8000 : 16'h7FFF, i[1] ? 32'h8000_0000 : 32'h7FFF_FFFF,
                             i[0] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF, i == 3));
      for (int unsigned i = 0; i < 5; i++)
         send_beat(random_beat(i == 4));
      req_valid <= 1'b0;
      drain_rows();

      for (int unsigned p = 0; p < 5; p++) begin
         write_scale(phase_scale[p]);
         phase_start = board.beats;
         // a full row closes with or without last
         send_row(MAX_LEN, p[0]);
         while (board.beats - phase_start < PHASE_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) n = $urandom_range(1, 8);
            else if (pick < 85) n = $urandom_range(9, 24);
            else if (pick < 95) n = $urandom_range(25, MAX_LEN - 1);
            else n = MAX_LEN;
            send_row(n, 1'($urandom_range(0, 1)));
         end
         req_valid <= 1'b0;
         drain_rows();
      end

      repeat (100) @(posedge clock);
      $display("%0d beats in %0d rows under %0d scale writes", board.beats, board.rows,
               scale_writes);
      $display("%0d results compared, %0d of them clamped", board.checked, board.clamped);
      if (board.errors == 0 && board.awaited.size() == 0) begin
         $display("symmetric_kernel_row_convolution_core_tb: done, clean");
      end else begin
         $display("symmetric_kernel_row_convolution_core_tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== symmetric_kernel_row_convolution_core.f =====
design/skrc_pkg.sv
design/skrc_ctrl.sv
design/skrc_dp.sv
design/symmetric_kernel_row_convolution_core.sv
dv/symmetric_kernel_row_convolution_core_tb.sv
